### rtl/core/uhash_pkg.sv
// ----------------------------------------------------------------------------
// uhash_pkg
// Shared types and constants for the UTF-8 string hash block: decode phases,
// the queue entry that carries one code unit or an end-of-string mark, and
// the queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package uhash_pkg;

  // Hash accumulator width default (range 16 to 64)
  localparam int HASH_WIDTH_DEFAULT = 32;

  // Output field width, fixed by the port
  localparam int HASH_OUT_WIDTH = 32;

  // Raw byte and decoded code unit widths
  localparam int BYTE_WIDTH = 8;
  localparam int UNIT_WIDTH = 16;

  // Payload widths of lead and continuation bytes
  localparam int LEAD_WIDTH   = 5;
  localparam int MIDDLE_WIDTH = 6;

  // Byte classification bit positions
  localparam int MULTI_BIT = 7;
  localparam int THREE_BIT = 5;

  // Multiplier 37 = 32 + 4 + 1, applied as shift-add
  localparam int MULT_SHIFT_HI = 5;
  localparam int MULT_SHIFT_LO = 2;

  // Queue between decoder and hash engine; depth is a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Decoder phases
  typedef enum logic [1:0] {
    PH_LEAD       = 2'd0,
    PH_TWO_LAST   = 2'd1,
    PH_THREE_MID  = 2'd2,
    PH_THREE_LAST = 2'd3
  } phase_t;

  // One queue entry: a code unit to fold, or the end of the string
  typedef struct packed {
    logic                  last;
    logic [UNIT_WIDTH-1:0] unit;
  } unit_entry_t;

endpackage

`default_nettype wire

### rtl/core/utf8_string_hash.sv
// ----------------------------------------------------------------------------
// utf8_string_hash
// Hashes zero-terminated strings given in modified UTF-8, one byte a beat.
// ----------------------------------------------------------------------------
// Feed string bytes on the byte channel; a zero byte in lead position ends
// the string and yields one beat on the hash channel holding the final
// hash (hash = hash*37 + code unit, modulo 2^HASH_WIDTH), after which the
// state is back at reset. A zero byte in continuation position is payload.
// The block takes one byte per cycle with no gaps, and the hash engine
// folds one code unit per cycle from a four-entry queue; the terminating
// byte's end mark passes through the queue into the output register. The
// byte side stalls only when that queue is full,
// which happens only while a finished hash waits on a stalled hash channel.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_string_hash
  import uhash_pkg::*;
#(
  parameter int HASH_WIDTH = HASH_WIDTH_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      byte_valid,
  output      logic                      byte_stall,
  input  wire logic [BYTE_WIDTH-1:0]     byte_value,
  output      logic                      hash_valid,
  input  wire logic                      hash_stall,
  output      logic [HASH_OUT_WIDTH-1:0] hash_value
);

  logic        push;
  unit_entry_t push_entry;
  logic        pop;
  logic        queue_full;
  logic        queue_empty;
  unit_entry_t head;

  // Decode bytes into code units
  uhash_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_value (byte_value),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Buffer units between decoder and hash engine
  uhash_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .empty      (queue_empty),
    .head       (head)
  );

  // Fold units and deliver the hash
  uhash_back #(
    .HASH_WIDTH (HASH_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head        (head),
    .pop         (pop),
    .hash_valid  (hash_valid),
    .hash_stall  (hash_stall),
    .hash_value  (hash_value)
  );

endmodule

`default_nettype wire

### rtl/core/uhash_front.sv
// ----------------------------------------------------------------------------
// uhash_front
// Byte decoder. Accepts one string byte per beat, tracks the modified UTF-8
// phase and pushes a complete code unit, or an end-of-string mark, into the
// queue.
// ----------------------------------------------------------------------------
`default_nettype none

module uhash_front
  import uhash_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  byte_valid,
  output      logic                  byte_stall,
  input  wire logic [BYTE_WIDTH-1:0] byte_value,
  input  wire logic                  queue_full,
  output      logic                  push,
  output      unit_entry_t           push_entry
);

  phase_t                  phase, phase_next;
  logic [LEAD_WIDTH-1:0]   lead_bits, lead_bits_next;
  logic [MIDDLE_WIDTH-1:0] middle_bits, middle_bits_next;
  logic                    accept;
  logic                    emit;

  // Hold the byte while the queue has no room
  assign byte_stall = queue_full;
  assign accept     = byte_valid && !queue_full;
  assign push       = accept && emit;

  // Decode the byte against the current phase
  always_comb begin
    phase_next       = phase;
    lead_bits_next   = lead_bits;
    middle_bits_next = middle_bits;
    emit             = 1'b0;
    push_entry       = '0;
    unique case (phase)
      PH_LEAD: begin
        if (byte_value == '0) begin
          // end of string: flush the hash
          emit            = 1'b1;
          push_entry.last = 1'b1;
        end else if (!byte_value[MULTI_BIT]) begin
          emit            = 1'b1;
          push_entry.unit = UNIT_WIDTH'(byte_value);
        end else if (!byte_value[THREE_BIT]) begin
          lead_bits_next = byte_value[LEAD_WIDTH-1:0];
          phase_next     = PH_TWO_LAST;
        end else begin
          lead_bits_next = {1'b0, byte_value[LEAD_WIDTH-2:0]};
          phase_next     = PH_THREE_MID;
        end
      end
      PH_TWO_LAST: begin
        emit            = 1'b1;
        push_entry.unit = UNIT_WIDTH'({lead_bits, byte_value[MIDDLE_WIDTH-1:0]});
        lead_bits_next  = '0;
        phase_next      = PH_LEAD;
      end
      PH_THREE_MID: begin
        middle_bits_next = byte_value[MIDDLE_WIDTH-1:0];
        phase_next       = PH_THREE_LAST;
      end
      PH_THREE_LAST: begin
        emit             = 1'b1;
        push_entry.unit  = {lead_bits[LEAD_WIDTH-2:0], middle_bits,
                            byte_value[MIDDLE_WIDTH-1:0]};
        lead_bits_next   = '0;
        middle_bits_next = '0;
        phase_next       = PH_LEAD;
      end
      default: begin
        phase_next = PH_LEAD;
      end
    endcase
  end

  // Advance the phase on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEAD;
      lead_bits   <= '0;
      middle_bits <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      lead_bits   <= lead_bits_next;
      middle_bits <= middle_bits_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/uhash_queue.sv
// ----------------------------------------------------------------------------
// uhash_queue
// Short FIFO of decoded code units between the decoder and the hash engine.
// Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module uhash_queue
  import uhash_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire unit_entry_t push_entry,
  input  wire logic        pop,
  output      logic        full,
  output      logic        empty,
  output      unit_entry_t head
);

  unit_entry_t            entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and track fill; pointers wrap at the power-of-two depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/uhash_back.sv
// ----------------------------------------------------------------------------
// uhash_back
// Hash engine. Pops one code unit per cycle while the queue is not empty,
// folds it as hash*37 + unit with shift-add, and on the end-of-string mark,
// once the output register is free, loads it and clears the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module uhash_back
  import uhash_pkg::*;
#(
  parameter int HASH_WIDTH = HASH_WIDTH_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      queue_empty,
  input  wire unit_entry_t               head,
  output      logic                      pop,
  output      logic                      hash_valid,
  input  wire logic                      hash_stall,
  output      logic [HASH_OUT_WIDTH-1:0] hash_value
);

  logic [HASH_WIDTH-1:0]                accumulator;
  logic [HASH_WIDTH-1:0]                accumulator_next;
  logic [HASH_WIDTH+HASH_OUT_WIDTH-1:0] acc_ext;
  logic                                 out_free;

  // The output register is free when empty or being taken this cycle
  assign out_free = !hash_valid || !hash_stall;
  assign pop      = !queue_empty && (!head.last || out_free);

  // Fold: hash*37 + unit, wrapping at HASH_WIDTH
  assign accumulator_next = (accumulator << MULT_SHIFT_HI) + (accumulator << MULT_SHIFT_LO)
                          + accumulator + HASH_WIDTH'(head.unit);

  // Zero-extend or truncate the accumulator to the output field
  assign acc_ext = {{HASH_OUT_WIDTH{1'b0}}, accumulator};

  // Update the accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
    end else if (pop) begin
      if (head.last) begin
        accumulator <= '0;
      end else begin
        accumulator <= accumulator_next;
      end
    end
  end

  // Load and drop the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
    end else if (pop && head.last) begin
      hash_valid <= 1'b1;
    end else if (!hash_stall) begin
      hash_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      hash_value <= acc_ext[HASH_OUT_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire
